/* sv/char_lcd_i2c_nibble_sequencer_macros.svh */
// Assertion macros for the nibble sequencer; clk and rst come from the using module.
`ifndef CHAR_LCD_I2C_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_I2C_NIBBLE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define CLNIB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in nibble sequencer");
`define CLNIB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in nibble sequencer");
`else
`define CLNIB_ASSERT_IMP(lbl, ante, cons)
`define CLNIB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/clnib_pkg.sv */
`timescale 1ns / 1ps
package clnib_pkg;

  typedef enum logic [3:0] {
    OP_RAW    = 4'd0,
    OP_INIT   = 4'd1,
    OP_CHAR   = 4'd2,
    OP_CUR_R  = 4'd3,
    OP_CUR_L  = 4'd4,
    OP_SHF_R  = 4'd5,
    OP_SHF_L  = 4'd6,
    OP_LINE1  = 4'd7,
    OP_LINE2  = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    REG_RS     = 3'd0,
    REG_RW     = 3'd1,
    REG_ENABLE = 3'd2,
    REG_LIGHT  = 3'd3,
    REG_D4     = 3'd4,
    REG_D5     = 3'd5,
    REG_D6     = 3'd6,
    REG_D7     = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_RAW,
    SRC_VAL_HI,
    SRC_VAL_LO,
    SRC_ARG
  } src_t;

  localparam logic [1:0] PAUSE_NONE = 2'd0;
  localparam logic [1:0] PAUSE_50US = 2'd1;
  localparam logic [1:0] PAUSE_5MS  = 2'd2;

  localparam int PC_W      = 5;
  localparam int UCODE_LEN = 17;

  localparam logic [PC_W-1:0] ENTRY_RAW  = 5'd0;
  localparam logic [PC_W-1:0] ENTRY_INIT = 5'd1;
  localparam logic [PC_W-1:0] ENTRY_CHAR = 5'd11;
  localparam logic [PC_W-1:0] ENTRY_STEP = 5'd13;
  localparam logic [PC_W-1:0] ENTRY_LINE = 5'd15;

  typedef struct packed {
    logic [2:0] rs_bit;
    logic [2:0] rw_bit;
    logic [2:0] enable_bit;
    logic [2:0] light_bit;
    logic [2:0] d4_bit;
    logic [2:0] d5_bit;
    logic [2:0] d6_bit;
    logic [2:0] d7_bit;
  } map_cfg_t;

  localparam map_cfg_t MAP_CFG_RESET = '{
    rs_bit: 3'd0, rw_bit: 3'd1, enable_bit: 3'd2, light_bit: 3'd3,
    d4_bit: 3'd4, d5_bit: 3'd5, d6_bit: 3'd6, d7_bit: 3'd7
  };

  typedef struct packed {
    src_t       src;
    logic [3:0] nib;
    logic       rs;
    logic [1:0] pause;
    logic       fin;
    logic       loop;
  } uword_t;

  function automatic uword_t uw(src_t src, logic [3:0] nib, logic rs,
                                logic [1:0] pause, logic fin, logic loop);
    uword_t w;
    w.src   = src;
    w.nib   = nib;
    w.rs    = rs;
    w.pause = pause;
    w.fin   = fin;
    w.loop  = loop;
    return w;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = uw(SRC_RAW,    4'h0, 1'b0, PAUSE_NONE, 1'b1, 1'b0);
      5'd1:    w = uw(SRC_CONST,  4'h3, 1'b0, PAUSE_5MS,  1'b0, 1'b0);
      5'd2:    w = uw(SRC_CONST,  4'h3, 1'b0, PAUSE_5MS,  1'b0, 1'b0);
      5'd3:    w = uw(SRC_CONST,  4'h3, 1'b0, PAUSE_5MS,  1'b0, 1'b0);
      5'd4:    w = uw(SRC_CONST,  4'h2, 1'b0, PAUSE_5MS,  1'b0, 1'b0);
      5'd5:    w = uw(SRC_CONST,  4'h2, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd6:    w = uw(SRC_CONST,  4'h8, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd7:    w = uw(SRC_CONST,  4'h0, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd8:    w = uw(SRC_CONST,  4'h6, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd9:    w = uw(SRC_CONST,  4'h0, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd10:   w = uw(SRC_CONST,  4'hF, 1'b0, PAUSE_NONE, 1'b1, 1'b0);
      5'd11:   w = uw(SRC_VAL_HI, 4'h0, 1'b1, PAUSE_NONE, 1'b0, 1'b0);
      5'd12:   w = uw(SRC_VAL_LO, 4'h0, 1'b1, PAUSE_50US, 1'b1, 1'b0);
      5'd13:   w = uw(SRC_CONST,  4'h1, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd14:   w = uw(SRC_ARG,    4'h0, 1'b0, PAUSE_NONE, 1'b1, 1'b1);
      5'd15:   w = uw(SRC_ARG,    4'h0, 1'b0, PAUSE_NONE, 1'b0, 1'b0);
      5'd16:   w = uw(SRC_CONST,  4'h0, 1'b0, PAUSE_NONE, 1'b1, 1'b0);
      default: w = uw(SRC_CONST,  4'h0, 1'b0, PAUSE_NONE, 1'b1, 1'b0);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_of(logic [3:0] op);
    logic [PC_W-1:0] e;
    unique case (op)
      OP_RAW:                              e = ENTRY_RAW;
      OP_INIT:                             e = ENTRY_INIT;
      OP_CHAR:                             e = ENTRY_CHAR;
      OP_CUR_R, OP_CUR_L, OP_SHF_R, OP_SHF_L: e = ENTRY_STEP;
      default:                             e = ENTRY_LINE;
    endcase
    return e;
  endfunction

  function automatic logic [3:0] arg_of(logic [3:0] op);
    logic [3:0] a;
    unique case (op)
      OP_CUR_R: a = 4'h4;
      OP_SHF_R: a = 4'hC;
      OP_SHF_L: a = 4'h8;
      OP_LINE1: a = 4'h8;
      OP_LINE2: a = 4'hC;
      default:  a = 4'h0;
    endcase
    return a;
  endfunction

endpackage

/* sv/clnib_map.sv */
`timescale 1ns / 1ps
module clnib_map (
  input  logic [7:0]          pins,
  input  clnib_pkg::map_cfg_t cfg,
  input  logic                drop_en,
  output logic [7:0]          bus
);
  import clnib_pkg::*;

  always_comb begin
    bus = 8'(pins[7]) << cfg.enable_bit;
    bus = bus | (8'(pins[6]) << cfg.light_bit);
    bus = bus | (8'(pins[5]) << cfg.rs_bit);
    bus = bus | (8'(pins[4]) << cfg.rw_bit);
    bus = bus | (8'(pins[3]) << cfg.d7_bit);
    bus = bus | (8'(pins[2]) << cfg.d6_bit);
    bus = bus | (8'(pins[1]) << cfg.d5_bit);
    bus = bus | (8'(pins[0]) << cfg.d4_bit);
    if (drop_en) begin
      bus[cfg.enable_bit] = 1'b0;
    end
  end

endmodule

/* sv/char_lcd_i2c_nibble_sequencer.sv */
`timescale 1ns / 1ps
// Timing: the first bus byte is on the outputs in the cycle after start is taken.
// Throughput: one bus byte per cycle, two per nibble step of the microcode ROM;
// a command gives 2 (raw), 4 (char, line), 20 (init) or 4 x repeat bytes, repeat
// capped at REPEAT_MAX. Unknown opcodes and zero-repeat step commands give no bytes.
// Reset: sequencer idle, position registers back to 0..7; results cannot be stalled.
`include "char_lcd_i2c_nibble_sequencer_macros.svh"
module char_lcd_i2c_nibble_sequencer #(
  parameter int REPEAT_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] opcode,
  input  logic [7:0] byte_value,
  input  logic [4:0] repeat_count,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_data,
  output logic       strobe,
  output logic [7:0] bus_byte,
  output logic [1:0] pause_after,
  output logic       last
);
  import clnib_pkg::*;

  localparam logic [4:0] REP_LIM = 5'(REPEAT_MAX);

  st_t             state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            phase, phase_next;
  logic [4:0]      cnt, cnt_next;
  logic [7:0]      val;
  logic [3:0]      arg;
  map_cfg_t        cfg;
  uword_t          uw_cur;
  logic            accept, cmd_ok, is_step, again, done;
  logic [7:0]      pins;

  assign accept  = start && (state == ST_IDLE);
  assign is_step = (opcode == OP_CUR_R) || (opcode == OP_CUR_L) ||
                   (opcode == OP_SHF_R) || (opcode == OP_SHF_L);
  assign cmd_ok  = (opcode <= OP_LINE2) && !(is_step && (repeat_count == 5'd0));
  assign uw_cur  = ucode(pc);
  assign again   = uw_cur.loop && (cnt > 5'd1);
  assign done    = phase && uw_cur.fin && !again;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd_ok) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state == ST_RUN);
    strobe = (state == ST_RUN);
  end

  always_comb begin
    pc_next    = pc;
    phase_next = phase;
    cnt_next   = cnt;
    if (state == ST_IDLE) begin
      pc_next    = entry_of(opcode);
      phase_next = 1'b0;
      cnt_next   = (repeat_count > REP_LIM) ? REP_LIM : repeat_count;
    end else if (!phase) begin
      phase_next = 1'b1;
    end else begin
      phase_next = 1'b0;
      if (again) begin
        pc_next  = ENTRY_STEP;
        cnt_next = cnt - 5'd1;
      end else begin
        pc_next = pc + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      phase <= 1'b0;
      cnt   <= '0;
      cfg   <= MAP_CFG_RESET;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RS:     cfg.rs_bit     <= cfg_data;
          REG_RW:     cfg.rw_bit     <= cfg_data;
          REG_ENABLE: cfg.enable_bit <= cfg_data;
          REG_LIGHT:  cfg.light_bit  <= cfg_data;
          REG_D4:     cfg.d4_bit     <= cfg_data;
          REG_D5:     cfg.d5_bit     <= cfg_data;
          REG_D6:     cfg.d6_bit     <= cfg_data;
          REG_D7:     cfg.d7_bit     <= cfg_data;
          default:    cfg.rs_bit     <= cfg.rs_bit;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val <= byte_value;
      arg <= arg_of(opcode);
    end
  end

  always_comb begin
    unique case (uw_cur.src)
      SRC_RAW:    pins = val;
      SRC_VAL_HI: pins = {2'b11, uw_cur.rs, 1'b0, val[7:4]};
      SRC_VAL_LO: pins = {2'b11, uw_cur.rs, 1'b0, val[3:0]};
      SRC_ARG:    pins = {2'b11, uw_cur.rs, 1'b0, arg};
      default:    pins = {2'b11, uw_cur.rs, 1'b0, uw_cur.nib};
    endcase
  end

  clnib_map u_map (
    .pins    (pins),
    .cfg     (cfg),
    .drop_en (phase),
    .bus     (bus_byte)
  );

  assign pause_after = phase ? uw_cur.pause : PAUSE_NONE;
  assign last        = strobe && done;

  `CLNIB_ASSERT_NXT(a_second_byte, strobe && !phase, strobe && phase)
  `CLNIB_ASSERT_NXT(a_idle_after_last, strobe && last, !busy)
  `CLNIB_ASSERT_IMP(a_pause_on_second, pause_after != PAUSE_NONE, strobe && phase)
  `CLNIB_ASSERT_IMP(a_pc_in_rom, busy, pc < 5'(UCODE_LEN))

endmodule

/* tb/lcd_bus_byte_checker.sv */
`timescale 1ns / 1ps
module lcd_bus_byte_checker #(
  parameter int REPEAT_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [3:0] opcode,
  input  logic [7:0] byte_value,
  input  logic [4:0] repeat_count,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       strobe,
  input  logic [7:0] bus_byte,
  input  logic [1:0] pause_after,
  input  logic       last,
  output int         errors,
  output int         pending,
  output int         bytes_seen
);
  import clnib_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] pause;
    logic       fin;
  } bus_word_t;

  localparam logic [39:0] INIT_NIBBLES = 40'h333228060F;

  bus_word_t bus_bytes_due[$];
  map_cfg_t  pin_map;
  int        fail_count;
  int        byte_count;

  function automatic logic [7:0] place_pins(map_cfg_t m, logic [7:0] v);
    logic [7:0] b;
    b = '0;
    b[m.enable_bit] |= v[7];
    b[m.light_bit]  |= v[6];
    b[m.rs_bit]     |= v[5];
    b[m.rw_bit]     |= v[4];
    b[m.d7_bit]     |= v[3];
    b[m.d6_bit]     |= v[2];
    b[m.d5_bit]     |= v[1];
    b[m.d4_bit]     |= v[0];
    return b;
  endfunction

  function automatic void queue_pins(logic [7:0] v, logic [1:0] pause);
    logic [7:0] b;
    b = place_pins(pin_map, v);
    bus_bytes_due.push_back('{b, PAUSE_NONE, 1'b0});
    b[pin_map.enable_bit] = 1'b0;
    bus_bytes_due.push_back('{b, pause, 1'b0});
  endfunction

  function automatic void queue_nibble(logic rs, logic [3:0] nib, logic [1:0] pause);
    queue_pins({2'b11, rs, 1'b0, nib}, pause);
  endfunction

  function automatic void expand_command(logic [3:0] op, logic [7:0] val, logic [4:0] cnt);
    int         start_len;
    int         steps;
    logic [3:0] arg;
    start_len = bus_bytes_due.size();
    steps = (cnt > REPEAT_MAX) ? REPEAT_MAX : int'(cnt);
    case (op)
      OP_RAW: queue_pins(val, PAUSE_NONE);
      OP_INIT: begin
        for (int i = 0; i < 10; i++)
          queue_nibble(1'b0, INIT_NIBBLES[39 - 4 * i -: 4], (i < 4) ? PAUSE_5MS : PAUSE_NONE);
      end
      OP_CHAR: begin
        queue_nibble(1'b1, val[7:4], PAUSE_NONE);
        queue_nibble(1'b1, val[3:0], PAUSE_50US);
      end
      OP_CUR_R, OP_CUR_L, OP_SHF_R, OP_SHF_L: begin
        case (op)
          OP_CUR_R: arg = 4'h4;
          OP_CUR_L: arg = 4'h0;
          OP_SHF_R: arg = 4'hC;
          default:  arg = 4'h8;
        endcase
        for (int i = 0; i < steps; i++) begin
          queue_nibble(1'b0, 4'h1, PAUSE_NONE);
          queue_nibble(1'b0, arg, PAUSE_NONE);
        end
      end
      OP_LINE1, OP_LINE2: begin
        queue_nibble(1'b0, (op == OP_LINE1) ? 4'h8 : 4'hC, PAUSE_NONE);
        queue_nibble(1'b0, 4'h0, PAUSE_NONE);
      end
      default: ;
    endcase
    if (bus_bytes_due.size() > start_len)
      bus_bytes_due[bus_bytes_due.size() - 1].fin = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    bus_word_t due;
    if (rst) begin
      bus_bytes_due.delete();
      pin_map = MAP_CFG_RESET;
      fail_count = 0;
      byte_count = 0;
    end else begin
      if (strobe) begin
        byte_count++;
        if (bus_bytes_due.size() == 0) begin
          fail_count++;
          $display("%0t: extra bus byte: expected none, actual %h pause %0d last %b",
                   $time, bus_byte, pause_after, last);
        end else begin
          due = bus_bytes_due.pop_front();
          if (bus_byte !== due.data) begin
            fail_count++;
            $display("%0t: bus_byte: expected %h, actual %h", $time, due.data, bus_byte);
          end
          if (pause_after !== due.pause) begin
            fail_count++;
            $display("%0t: pause_after: expected %0d, actual %0d",
                     $time, due.pause, pause_after);
          end
          if (last !== due.fin) begin
            fail_count++;
            $display("%0t: last: expected %b, actual %b", $time, due.fin, last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RS:     pin_map.rs_bit = cfg_data;
          REG_RW:     pin_map.rw_bit = cfg_data;
          REG_ENABLE: pin_map.enable_bit = cfg_data;
          REG_LIGHT:  pin_map.light_bit = cfg_data;
          REG_D4:     pin_map.d4_bit = cfg_data;
          REG_D5:     pin_map.d5_bit = cfg_data;
          REG_D6:     pin_map.d6_bit = cfg_data;
          default:    pin_map.d7_bit = cfg_data;
        endcase
      end
      if (start && !busy)
        expand_command(opcode, byte_value, repeat_count);
    end
    errors <= fail_count;
    bytes_seen <= byte_count;
    pending <= bus_bytes_due.size();
  end

endmodule

/* tb/char_lcd_i2c_nibble_sequencer_test.sv */
`timescale 1ns / 1ps
module char_lcd_i2c_nibble_sequencer_test;
  import clnib_pkg::*;

  localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'hF;
  localparam int         PHASES = 6;
  localparam int         ITEMS_PER_PHASE = 36;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [3:0] opcode = '0;
  logic [7:0] byte_value = '0;
  logic [4:0] repeat_count = '0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;
  logic       strobe;
  logic [7:0] bus_byte;
  logic [1:0] pause_after;
  logic       last;

  int errors;
  int pending;
  int bytes_seen;
  int commands_run;
  int commands_ignored;
  int maps_written;

  char_lcd_i2c_nibble_sequencer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .byte_value(byte_value), .repeat_count(repeat_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .bus_byte(bus_byte), .pause_after(pause_after), .last(last)
  );

  lcd_bus_byte_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .byte_value(byte_value), .repeat_count(repeat_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .bus_byte(bus_byte), .pause_after(pause_after), .last(last),
    .errors(errors), .pending(pending), .bytes_seen(bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic bit is_ignored(logic [3:0] op, logic [4:0] cnt);
    return (op > OP_LINE2) || (op >= OP_CUR_R && op <= OP_SHF_L && cnt == 0);
  endfunction

  function automatic logic [2:0] map_field(map_cfg_t m, cfg_reg_t r);
    case (r)
      REG_RS:     return m.rs_bit;
      REG_RW:     return m.rw_bit;
      REG_ENABLE: return m.enable_bit;
      REG_LIGHT:  return m.light_bit;
      REG_D4:     return m.d4_bit;
      REG_D5:     return m.d5_bit;
      REG_D6:     return m.d6_bit;
      default:    return m.d7_bit;
    endcase
  endfunction

  task automatic run_command(logic [3:0] op, logic [7:0] val, logic [4:0] cnt, int idle_pct);
    start <= 1'b1;
    opcode <= op;
    byte_value <= val;
    repeat_count <= cnt;
    do @(posedge clk); while (busy);
    if (is_ignored(op, cnt))
      commands_ignored++;
    else
      commands_run++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // drain every expected byte and wait until the sequencer is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map(map_cfg_t m);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= map_field(m, cfg_reg_t'(i));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    maps_written++;
  endtask

  initial begin : stimulus
    map_cfg_t    m;
    logic [2:0]  perm [8];
    logic [2:0]  tmp;
    logic [31:0] r;
    logic [3:0]  op;
    logic [4:0]  cnt;
    int          idle_pct;
    int          done;
    int          k;
    int          pick;

    commands_run = 0;
    commands_ignored = 0;
    maps_written = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_command(OP_RAW, 8'h00, 5'd0, 0);
    run_command(OP_RAW, 8'hFF, 5'd31, 0);
    run_command(OP_RAW, 8'h80, 5'd3, 0);
    run_command(OP_RAW, 8'h7F, 5'd1, 0);
    run_command(OP_RAW, 8'hA5, 5'd9, 0);
    run_command(OP_INIT, 8'h3C, 5'd2, 0);
    run_command(OP_CHAR, 8'h00, 5'd0, 0);
    run_command(OP_CHAR, 8'hFF, 5'd31, 0);
    run_command(OP_CHAR, 8'h41, 5'd1, 0);
    run_command(OP_CUR_R, 8'h12, 5'd1, 0);
    run_command(OP_CUR_L, 8'h00, 5'd16, 0);
    run_command(OP_SHF_R, 8'hFF, 5'd31, 0);
    run_command(OP_SHF_L, 8'h5A, 5'd2, 0);
    run_command(OP_CUR_R, 8'h01, 5'd0, 0);
    run_command(OP_SHF_L, 8'h77, 5'd17, 0);
    run_command(OP_CUR_L, 8'h99, 5'd5, 0);
    run_command(OP_LINE1, 8'h00, 5'd0, 0);
    run_command(OP_LINE2, 8'hFF, 5'd31, 0);
    run_command(OP_UNKNOWN_LO, 8'hC3, 5'd4, 0);
    run_command(OP_UNKNOWN_HI, 8'hFF, 5'd31, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: m = MAP_CFG_RESET;
        1: m = '{rs_bit: 3'd7, rw_bit: 3'd6, enable_bit: 3'd5, light_bit: 3'd4,
                 d4_bit: 3'd3, d5_bit: 3'd2, d6_bit: 3'd1, d7_bit: 3'd0};
        2: m = '0;
        3: m = '1;
        4: begin
          for (int i = 0; i < 8; i++) perm[i] = i[2:0];
          for (int i = 7; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
          end
          m = {perm[0], perm[1], perm[2], perm[3], perm[4], perm[5], perm[6], perm[7]};
        end
        default: begin
          r = $urandom;
          m = r[23:0];
        end
      endcase
      write_map(m);
      idle_pct = (phase < 2) ? 23 : (phase < 4) ? 50 : 0;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        op = (pick < 8) ? 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI))
                        : 4'($urandom_range(OP_RAW, OP_LINE2));
        pick = $urandom_range(0, 99);
        if (pick < 70)
          cnt = 5'($urandom_range(1, 4));
        else if (pick < 78)
          cnt = 5'd0;
        else if (pick < 90)
          cnt = 5'($urandom_range(16, 31));
        else
          cnt = 5'($urandom_range(5, 15));
        run_command(op, 8'($urandom_range(0, 255)), cnt, idle_pct);
        if (!is_ignored(op, cnt))
          done++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d commands plus %0d ignored ones under %0d pin mappings",
             commands_run, commands_ignored, maps_written);
    $display("compared %0d bus bytes with %0d mismatches", bytes_seen, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
